// ----- rtl/operand_fetch_decode_defines.svh -----
// Assertion macros for the operand fetch and decode block.
// Used by the top level; expects clk and arst_n in scope where expanded.
`ifndef OPERAND_FETCH_DECODE_DEFINES_SVH
`define OPERAND_FETCH_DECODE_DEFINES_SVH

// Same-cycle implication, off during reset
`define OFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset
`define OFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ofd_pkg.sv -----
// Shared types, constants and microcode ROM for the operand fetch and decode block.
// No dependencies; every other file but the defines header imports this package.
package ofd_pkg;

	localparam int ADDR_W = 12;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 5;
	localparam int KIND_W = 2;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 3;
	localparam int NARGS  = 4;

	localparam logic [CNT_W-1:0] MAX_ARGS = 3'd4;

	// Argument kinds from the coding byte
	localparam logic [KIND_W-1:0] ARG_NONE = 2'd0;
	localparam logic [KIND_W-1:0] ARG_REG  = 2'd1;
	localparam logic [KIND_W-1:0] ARG_DIR  = 2'd2;
	localparam logic [KIND_W-1:0] ARG_IND  = 2'd3;

	// Command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	typedef logic [3:0] step_t;

	// Microprogram addresses
	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_DISP   = 4'd1;
	localparam step_t ST_CB     = 4'd2;
	localparam step_t ST_ASEL   = 4'd3;
	localparam step_t ST_TEST   = 4'd4;
	localparam step_t ST_BYTE   = 4'd5;
	localparam step_t ST_STORE  = 4'd6;
	localparam step_t ST_DIRECT = 4'd7;
	localparam step_t ST_FINISH = 4'd8;

	typedef enum logic [2:0] {
		C_ALWAYS   = 3'd0,
		C_START    = 3'd1,
		C_NO_CB    = 3'd2,
		C_DONE     = 3'd3,
		C_BC_ZERO  = 3'd4,
		C_BC_MORE  = 3'd5,
		C_OUT_FREE = 3'd6
	} cond_t;

	// One control word per microprogram step
	typedef struct packed {
		logic  accept;   // take an item from the command channel
		logic  consume;  // shift in the byte at the read pointer and advance
		logic  load_cb;  // capture the coding byte
		logic  arg_sel;  // set up the byte count of the current argument
		logic  direct;   // set up a lone direct argument
		logic  store;    // extend and store the gathered argument
		logic  emit;     // load the result register when it is free
		cond_t cond;
		step_t t_true;
		step_t t_false;
	} ctrl_t;

	// Status flags back to the sequencer
	typedef struct packed {
		logic start;
		logic no_cb;
		logic done;
		logic bc_zero;
		logic bc_more;
		logic out_free;
	} stat_t;

	// Microcode ROM
	function automatic ctrl_t ucode_rom(input step_t s);
		ctrl_t w;
		w = '0;
		w.cond = C_ALWAYS;
		w.t_true = ST_IDLE;
		w.t_false = ST_IDLE;
		case (s)
			ST_IDLE: begin
				w.accept = 1'b1;
				w.cond = C_START;
				w.t_true = ST_DISP;
				w.t_false = ST_IDLE;
			end
			ST_DISP: begin
				w.cond = C_NO_CB;
				w.t_true = ST_DIRECT;
				w.t_false = ST_CB;
			end
			ST_CB: begin
				w.consume = 1'b1;
				w.load_cb = 1'b1;
				w.t_true = ST_ASEL;
				w.t_false = ST_ASEL;
			end
			ST_ASEL: begin
				w.arg_sel = 1'b1;
				w.cond = C_DONE;
				w.t_true = ST_FINISH;
				w.t_false = ST_TEST;
			end
			ST_TEST: begin
				w.cond = C_BC_ZERO;
				w.t_true = ST_STORE;
				w.t_false = ST_BYTE;
			end
			ST_BYTE: begin
				w.consume = 1'b1;
				w.cond = C_BC_MORE;
				w.t_true = ST_BYTE;
				w.t_false = ST_STORE;
			end
			ST_STORE: begin
				w.store = 1'b1;
				w.t_true = ST_ASEL;
				w.t_false = ST_ASEL;
			end
			ST_DIRECT: begin
				w.direct = 1'b1;
				w.t_true = ST_BYTE;
				w.t_false = ST_BYTE;
			end
			ST_FINISH: begin
				w.emit = 1'b1;
				w.cond = C_OUT_FREE;
				w.t_true = ST_IDLE;
				w.t_false = ST_FINISH;
			end
			default: begin
				w.cond = C_ALWAYS;
			end
		endcase
		return w;
	endfunction

	// Bytes read for one argument
	function automatic logic [CNT_W-1:0] arg_bytes(input logic [KIND_W-1:0] kind,
		input logic wide);
		logic [CNT_W-1:0] n;
		case (kind)
			ARG_REG: n = 3'd1;
			ARG_DIR: n = wide ? 3'd4 : 3'd2;
			ARG_IND: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Extend gathered bytes by argument width
	function automatic logic [VAL_W-1:0] ext_value(input logic [VAL_W-1:0] acc,
		input logic [CNT_W-1:0] nb);
		logic [VAL_W-1:0] v;
		case (nb)
			3'd1: v = {24'd0, acc[7:0]};
			3'd2: v = {{16{acc[15]}}, acc[15:0]};
			3'd4: v = acc;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/ofd_cmd_if.sv -----
// Command channel: arena writes and decode requests, valid/ready handshake.
// Depends on ofd_pkg for field widths.
interface ofd_cmd_if import ofd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [ADDR_W-1:0] address;
	logic [BYTE_W-1:0] write_byte;
	logic              has_coding_byte;
	logic [CNT_W-1:0]  arg_count;
	logic              direct_wide;

	modport source (output valid, command, address, write_byte, has_coding_byte,
		arg_count, direct_wide, input ready);
	modport sink (input valid, command, address, write_byte, has_coding_byte,
		arg_count, direct_wide, output ready);
endinterface

// ----- rtl/ofd_res_if.sv -----
// Result channel: decoded length, argument kinds and values, valid/ready handshake.
// Depends on ofd_pkg for field widths.
interface ofd_res_if import ofd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [LEN_W-1:0]        instruction_length;
	logic [KIND_W-1:0]       type_one;
	logic [KIND_W-1:0]       type_two;
	logic [KIND_W-1:0]       type_three;
	logic [KIND_W-1:0]       type_four;
	logic signed [VAL_W-1:0] value_one;
	logic signed [VAL_W-1:0] value_two;
	logic signed [VAL_W-1:0] value_three;
	logic signed [VAL_W-1:0] value_four;

	modport source (output valid, instruction_length, type_one, type_two, type_three,
		type_four, value_one, value_two, value_three, value_four, input ready);
	modport sink (input valid, instruction_length, type_one, type_two, type_three,
		type_four, value_one, value_two, value_three, value_four, output ready);
endinterface

// ----- rtl/ofd_arena.sv -----
// Single-port byte arena with registered read data.
// Depends on ofd_pkg for the byte width.
module ofd_arena import ofd_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     addr,
	input  logic [BYTE_W-1:0] wdata,
	output logic [BYTE_W-1:0] rdata_q
);

	logic [BYTE_W-1:0] mem [DEPTH];

	// Write or read one byte per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

endmodule

// ----- rtl/ofd_useq.sv -----
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on ofd_pkg for the ROM, control word and status types.
module ofd_useq import ofd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t step_q;
	logic  take;

	assign ctrl = ucode_rom(step_q);

	// Evaluate the jump condition of the current word
	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:   take = 1'b1;
			C_START:    take = stat.start;
			C_NO_CB:    take = stat.no_cb;
			C_DONE:     take = stat.done;
			C_BC_ZERO:  take = stat.bc_zero;
			C_BC_MORE:  take = stat.bc_more;
			C_OUT_FREE: take = stat.out_free;
			default:    take = 1'b1;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= take ? ctrl.t_true : ctrl.t_false;
		end
	end

endmodule

// ----- rtl/ofd_dpath.sv -----
// Datapath: address wrap, read pointer, byte gathering, argument store and result register.
// Depends on ofd_pkg and both channel interfaces; driven by the sequencer's control word.
module ofd_dpath import ofd_pkg::*; #(
	parameter int ARENA_BYTES = 4096,
	parameter int AW = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	ofd_cmd_if.sink           cmd,
	ofd_res_if.source         res,
	input  ctrl_t             ctrl,
	output stat_t             stat,
	output logic              mem_we,
	output logic [AW-1:0]     mem_addr,
	output logic [BYTE_W-1:0] mem_wdata,
	input  logic [BYTE_W-1:0] mem_rdata
);

	logic                         start;
	logic                         wr;
	logic [AW-1:0]                red_addr;
	logic [AW-1:0]                pos_q;
	logic [AW-1:0]                pos_d;
	logic [LEN_W-1:0]             len_q;
	logic [BYTE_W-1:0]            cb_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [CNT_W-1:0]             idx_q;
	logic [CNT_W-1:0]             bc_q;
	logic [CNT_W-1:0]             nb_q;
	logic [CNT_W-1:0]             nb_d;
	logic [VAL_W-1:0]             acc_q;
	logic [NARGS-1:0][VAL_W-1:0]  vals_q;
	logic                         wide_q;
	logic                         hcb_q;
	logic [NARGS-1:0][KIND_W-1:0] kinds;
	logic [KIND_W-1:0]            cur_kind;
	logic                         out_valid_q;
	logic                         out_free;
	logic [LEN_W-1:0]             out_len_q;
	logic [NARGS-1:0][KIND_W-1:0] out_kinds_q;
	logic [NARGS-1:0][VAL_W-1:0]  out_vals_q;

	// Next arena address with wrap
	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		logic [AW:0] n;
		n = {1'b0, p} + 1'b1;
		if (n == (AW+1)'(ARENA_BYTES)) begin
			return '0;
		end
		return n[AW-1:0];
	endfunction

	assign start = cmd.valid && ctrl.accept && (cmd.command == CMD_DECODE);
	assign wr    = cmd.valid && ctrl.accept && (cmd.command == CMD_WRITE);
	assign cmd.ready = ctrl.accept;

	// Reduce the incoming address into the arena
	generate
		if (ARENA_BYTES >= (1 << ADDR_W)) begin : g_nowrap
			assign red_addr = AW'(cmd.address);
		end else begin : g_wrap
			localparam int FLOOR = $clog2(ARENA_BYTES + 1) - 1;
			localparam int KMAX = ADDR_W - 1 - FLOOR;
			logic [ADDR_W-1:0] rem;
			always_comb begin
				rem = cmd.address;
				for (int k = KMAX; k >= 0; k--) begin
					if ({1'b0, rem} >= (ADDR_W+1)'(ARENA_BYTES << k)) begin
						rem = rem - ADDR_W'(ARENA_BYTES << k);
					end
				end
			end
			assign red_addr = AW'(rem);
		end
	endgenerate

	// Read pointer for the next cycle; the memory reads there except during a write
	always_comb begin
		if (start) begin
			pos_d = wrap_inc(red_addr);
		end else if (ctrl.consume) begin
			pos_d = wrap_inc(pos_q);
		end else begin
			pos_d = pos_q;
		end
	end

	assign mem_we    = wr;
	assign mem_addr  = wr ? red_addr : pos_d;
	assign mem_wdata = cmd.write_byte;

	// Kind of the argument being decoded, argument one in the top field
	assign kinds    = cb_q;
	assign cur_kind = kinds[2'd3 - idx_q[1:0]];
	assign nb_d     = ctrl.direct ? (wide_q ? 3'd4 : 3'd2) : arg_bytes(cur_kind, wide_q);

	// Working registers of one decode
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (start) begin
			len_q  <= LEN_W'(1);
			cb_q   <= '0;
			cnt_q  <= !cmd.has_coding_byte ? CNT_W'(1) :
				(cmd.arg_count > MAX_ARGS ? MAX_ARGS : cmd.arg_count);
			idx_q  <= '0;
			vals_q <= '0;
			wide_q <= cmd.direct_wide;
			hcb_q  <= cmd.has_coding_byte;
		end else begin
			if (ctrl.consume) begin
				len_q <= len_q + 1'b1;
				acc_q <= {acc_q[VAL_W-BYTE_W-1:0], mem_rdata};
				bc_q  <= bc_q - 1'b1;
			end
			if (ctrl.load_cb) begin
				cb_q <= mem_rdata;
			end
			if (ctrl.arg_sel || ctrl.direct) begin
				bc_q  <= nb_d;
				nb_q  <= nb_d;
				acc_q <= '0;
			end
			if (ctrl.store) begin
				vals_q[idx_q[1:0]] <= ext_value(acc_q, nb_q);
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign out_free = !out_valid_q || res.ready;

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			out_len_q   <= len_q;
			out_kinds_q <= kinds;
			out_vals_q  <= vals_q;
		end
	end

	assign res.valid              = out_valid_q;
	assign res.instruction_length = out_len_q;
	assign res.type_one           = out_kinds_q[3];
	assign res.type_two           = out_kinds_q[2];
	assign res.type_three         = out_kinds_q[1];
	assign res.type_four          = out_kinds_q[0];
	assign res.value_one          = out_vals_q[0];
	assign res.value_two          = out_vals_q[1];
	assign res.value_three        = out_vals_q[2];
	assign res.value_four         = out_vals_q[3];

	// Status to the sequencer
	assign stat.start    = start;
	assign stat.no_cb    = !hcb_q;
	assign stat.done     = (idx_q == cnt_q);
	assign stat.bc_zero  = (bc_q == '0);
	assign stat.bc_more  = (bc_q != CNT_W'(1));
	assign stat.out_free = out_free;

endmodule

// ----- rtl/operand_fetch_decode.sv -----
// Operand fetch and decode over a circular byte arena.
// Depends on ofd_pkg, ofd_cmd_if, ofd_res_if, ofd_arena, ofd_useq, ofd_dpath and the defines header.
//
// A write item stores one byte and yields no result. A decode item is
// run by a small microprogram that reads the arena one byte per cycle through its
// single memory port. Without a coding byte it runs the dispatch and direct steps,
// a byte step per direct byte, then store, select and finish. With a coding byte
// it runs the dispatch and coding-byte steps, then for each decoded argument the
// sequencer's select, test, byte and store steps, then a last select and finish. The
// next item is taken once the result is loaded into the output register, which
// then waits for the sink on its own. Arena contents are undefined until written.
`include "operand_fetch_decode_defines.svh"

module operand_fetch_decode import ofd_pkg::*; #(
	parameter int ARENA_BYTES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	ofd_cmd_if.sink   cmd,
	ofd_res_if.source res
);

	localparam int AW = $clog2(ARENA_BYTES);

	ctrl_t             ctrl;
	stat_t             stat;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [BYTE_W-1:0] mem_rdata;

	ofd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	ofd_dpath #(
		.ARENA_BYTES (ARENA_BYTES),
		.AW          (AW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.ctrl      (ctrl),
		.stat      (stat),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	ofd_arena #(
		.DEPTH (ARENA_BYTES),
		.AW    (AW)
	) u_arena (
		.clk     (clk),
		.we      (mem_we),
		.addr    (mem_addr),
		.wdata   (mem_wdata),
		.rdata_q (mem_rdata)
	);

	// A decode item keeps the block busy for at least the next cycle
	`OFD_ASSERT_NEXT(a_busy_after_decode, cmd.valid && cmd.ready && (cmd.command == CMD_DECODE), !cmd.ready, "command channel ready right after a decode item")
	// A result appears only from the finish step of the microprogram
	`OFD_ASSERT_NOW(a_result_from_emit, $rose(res.valid), $past(ctrl.emit), "result valid without an emit step")
	// Offered length stays within opcode plus coding byte plus four wide arguments
	`OFD_ASSERT_NOW(a_length_range, res.valid, (res.instruction_length >= 5'd1) && (res.instruction_length <= 5'd18), "instruction length out of range")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for operand_fetch_decode: arena byte writes and operand decodes.
// Depends on ofd_pkg, ofd_cmd_if, ofd_res_if and the operand_fetch_decode top level.
module tb;
	import ofd_pkg::*;

	localparam int ARENA_DEPTH    = 4096;
	localparam int ITEM_TARGET    = 1300;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef enum logic [1:0] {
		SLOT_ITEM,
		SLOT_HOLD,
		SLOT_DRAIN
	} slot_kind_t;

	// One entry of the command stream, or a pacing marker
	typedef struct {
		slot_kind_t        slot;
		logic              command;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] write_byte;
		logic              has_coding_byte;
		logic [CNT_W-1:0]  arg_count;
		logic              direct_wide;
		int                gap;
		logic              calm;
	} cmd_slot_t;

	// Index 0 is argument one
	typedef struct packed {
		logic [LEN_W-1:0]             instr_len;
		logic [NARGS-1:0][KIND_W-1:0] arg_kind;
		logic [NARGS-1:0][VAL_W-1:0]  arg_value;
	} decode_result_t;

	logic clk;
	logic arst_n;

	ofd_cmd_if cmd_ch ();
	ofd_res_if res_ch ();

	operand_fetch_decode #(
		.ARENA_BYTES(ARENA_DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	// Stimulus planning state, kept apart from the arena seen at acceptance
	logic [BYTE_W-1:0] plan_bytes [ARENA_DEPTH];
	bit                plan_known [ARENA_DEPTH];
	logic [BYTE_W-1:0] arena_shadow [ARENA_DEPTH];

	cmd_slot_t      stim_q[$];
	decode_result_t pending_decodes[$];
	cmd_slot_t      in_flight;

	int   queued_items;
	int   errors;
	bit   gen_bursty;
	bit   gen_calm;
	int   hold_req;
	logic rx_calm;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int operand_bytes(input logic [KIND_W-1:0] arg, input logic wide);
		case (arg)
			ARG_REG: return 1;
			ARG_DIR: return wide ? 4 : 2;
			ARG_IND: return 2;
			default: return 0;
		endcase
	endfunction

	// Gather nb big-endian bytes from the shadow arena and extend them
	function automatic logic [VAL_W-1:0] fetch_operand(input logic [ADDR_W-1:0] start,
		input int nb);
		logic [VAL_W-1:0] acc;
		acc = '0;
		for (int b = 0; b < nb; b++)
			acc = {acc[VAL_W-9:0], arena_shadow[ADDR_W'(start + b)]};
		case (nb)
			1: return {24'd0, acc[7:0]};
			2: return {{16{acc[15]}}, acc[15:0]};
			default: return acc;
		endcase
	endfunction

	// Predict the result of one decode against the shadow arena
	function automatic decode_result_t decode_operands(input logic [ADDR_W-1:0] at,
		input logic cb_flag, input logic [CNT_W-1:0] count, input logic wide);
		decode_result_t r;
		logic [ADDR_W-1:0] pos;
		logic [BYTE_W-1:0] cb;
		int n;
		int nb;
		r = '0;
		r.instr_len = LEN_W'(1);
		pos = ADDR_W'(at + 1);
		if (cb_flag) begin
			cb = arena_shadow[pos];
			pos = ADDR_W'(pos + 1);
			r.instr_len = LEN_W'(r.instr_len + 1);
			for (int i = 0; i < NARGS; i++)
				r.arg_kind[i] = KIND_W'(cb >> (6 - 2 * i));
			n = (count > MAX_ARGS) ? int'(MAX_ARGS) : int'(count);
			for (int i = 0; i < n; i++) begin
				nb = operand_bytes(r.arg_kind[i], wide);
				r.arg_value[i] = fetch_operand(pos, nb);
				pos = ADDR_W'(pos + nb);
				r.instr_len = LEN_W'(r.instr_len + nb);
			end
		end else begin
			nb = wide ? 4 : 2;
			r.arg_value[0] = fetch_operand(pos, nb);
			r.instr_len = LEN_W'(r.instr_len + nb);
		end
		return r;
	endfunction

	// Instruction length as the planned arena contents make it
	function automatic int instruction_span(input logic [ADDR_W-1:0] at, input logic cb_flag,
		input logic [CNT_W-1:0] count, input logic wide);
		logic [BYTE_W-1:0] cb;
		int len;
		int n;
		if (!cb_flag)
			return wide ? 5 : 3;
		cb = plan_bytes[ADDR_W'(at + 1)];
		len = 2;
		n = (count > MAX_ARGS) ? int'(MAX_ARGS) : int'(count);
		for (int i = 0; i < n; i++)
			len += operand_bytes(KIND_W'(cb >> (6 - 2 * i)), wide);
		return len;
	endfunction

	function automatic logic [BYTE_W-1:0] random_byte();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		if (gen_bursty && $urandom_range(0, 3) == 0)
			return $urandom_range(1, 13);
		return 0;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected 0x%h actual 0x%h", $time, name, want, got);
		end
	endfunction

	task automatic queue_marker(input slot_kind_t kind_of);
		cmd_slot_t s;
		s.slot = kind_of;
		s.command = CMD_WRITE;
		s.address = '0;
		s.write_byte = '0;
		s.has_coding_byte = 1'b0;
		s.arg_count = '0;
		s.direct_wide = 1'b0;
		s.gap = 0;
		s.calm = 1'b1;
		stim_q.push_back(s);
	endtask

	task automatic queue_write(input logic [ADDR_W-1:0] at, input logic [BYTE_W-1:0] data);
		cmd_slot_t s;
		s.slot = SLOT_ITEM;
		s.command = CMD_WRITE;
		s.address = at;
		s.write_byte = data;
		s.has_coding_byte = 1'($urandom_range(0, 1));
		s.arg_count = CNT_W'($urandom_range(0, 7));
		s.direct_wide = 1'($urandom_range(0, 1));
		s.gap = pick_gap();
		s.calm = gen_calm;
		stim_q.push_back(s);
		plan_bytes[at] = data;
		plan_known[at] = 1'b1;
		queued_items++;
	endtask

	// Fill any unwritten byte the decode would read, then queue the decode
	task automatic queue_decode(input logic [ADDR_W-1:0] at, input logic cb_flag,
		input logic [CNT_W-1:0] count, input logic wide);
		cmd_slot_t s;
		logic [ADDR_W-1:0] p;
		int len;
		p = ADDR_W'(at + 1);
		if (cb_flag && !plan_known[p])
			queue_write(p, random_byte());
		len = instruction_span(at, cb_flag, count, wide);
		for (int k = 1; k < len; k++) begin
			p = ADDR_W'(at + k);
			if (!plan_known[p])
				queue_write(p, random_byte());
		end
		s.slot = SLOT_ITEM;
		s.command = CMD_DECODE;
		s.address = at;
		s.write_byte = BYTE_W'($urandom);
		s.has_coding_byte = cb_flag;
		s.arg_count = count;
		s.direct_wide = wide;
		s.gap = pick_gap();
		s.calm = gen_calm;
		stim_q.push_back(s);
		queued_items++;
	endtask

	// Write a whole instruction with random content, then decode it
	task automatic queue_fresh_instruction();
		logic [ADDR_W-1:0] at;
		logic [ADDR_W-1:0] p;
		logic              cb_flag;
		logic [CNT_W-1:0]  count;
		logic              wide;
		logic [BYTE_W-1:0] cb;
		int                len;
		if ($urandom_range(0, 7) == 0)
			at = ADDR_W'($urandom_range(ARENA_DEPTH - 18, ARENA_DEPTH - 1));
		else
			at = ADDR_W'($urandom);
		cb_flag = ($urandom_range(0, 4) != 0);
		if ($urandom_range(0, 7) == 0)
			count = CNT_W'($urandom_range(0, 7));
		else
			count = CNT_W'($urandom_range(1, 4));
		wide = 1'($urandom_range(0, 1));
		cb = BYTE_W'($urandom);
		// longest form: four wide directs
		if ($urandom_range(0, 7) == 0) begin
			cb = 8'hAA;
			count = MAX_ARGS;
			wide = 1'b1;
		end
		p = ADDR_W'(at + 1);
		if (cb_flag)
			queue_write(p, cb);
		len = instruction_span(at, cb_flag, count, wide);
		for (int k = cb_flag ? 2 : 1; k < len; k++) begin
			p = ADDR_W'(at + k);
			queue_write(p, random_byte());
		end
		queue_decode(at, cb_flag, count, wide);
	endtask

	// Drive the command channel from the pending queue, predict on acceptance
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		cmd_slot_t head;
		logic      offer;
		int        send_wait;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.command <= CMD_WRITE;
			cmd_ch.address <= '0;
			cmd_ch.write_byte <= '0;
			cmd_ch.has_coding_byte <= 1'b0;
			cmd_ch.arg_count <= '0;
			cmd_ch.direct_wide <= 1'b0;
			hold_req <= 0;
			rx_calm <= 1'b1;
			send_wait = 0;
		end else begin
			offer = cmd_ch.valid;
			if (cmd_ch.valid && cmd_ch.ready) begin
				offer = 1'b0;
				if (in_flight.command == CMD_DECODE)
					pending_decodes.push_back(decode_operands(in_flight.address,
						in_flight.has_coding_byte, in_flight.arg_count, in_flight.direct_wide));
				else
					arena_shadow[in_flight.address] = in_flight.write_byte;
			end
			if (!offer) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (stim_q.size() > 0) begin
					head = stim_q[0];
					case (head.slot)
						SLOT_HOLD: begin
							hold_req <= hold_req + 1;
							stim_q.delete(0);
						end
						SLOT_DRAIN: begin
							if (pending_decodes.size() == 0)
								stim_q.delete(0);
						end
						default: begin
							if (head.gap > 0) begin
								send_wait = head.gap - 1;
								stim_q[0].gap = 0;
							end else begin
								cmd_ch.command <= head.command;
								cmd_ch.address <= head.address;
								cmd_ch.write_byte <= head.write_byte;
								cmd_ch.has_coding_byte <= head.has_coding_byte;
								cmd_ch.arg_count <= head.arg_count;
								cmd_ch.direct_wide <= head.direct_wide;
								rx_calm <= head.calm;
								in_flight = head;
								offer = 1'b1;
								stim_q.delete(0);
							end
						end
					endcase
				end
			end
			cmd_ch.valid <= offer;
		end
	end

	// Take results, compare against the oldest prediction, pace ready
	always @(posedge clk or negedge arst_n) begin : res_monitor
		decode_result_t want;
		logic           take;
		int             stall_left;
		int             hold_left;
		int             hold_seen;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			hold_seen = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_decodes.size() == 0) begin
					errors++;
					$display("%0t ns: result with no decode pending, length 0x%h", $time,
						res_ch.instruction_length);
				end else begin
					want = pending_decodes.pop_front();
					check_field("instruction_length", 32'(want.instr_len),
						32'(res_ch.instruction_length));
					check_field("type_one", 32'(want.arg_kind[0]), 32'(res_ch.type_one));
					check_field("type_two", 32'(want.arg_kind[1]), 32'(res_ch.type_two));
					check_field("type_three", 32'(want.arg_kind[2]), 32'(res_ch.type_three));
					check_field("type_four", 32'(want.arg_kind[3]), 32'(res_ch.type_four));
					check_field("value_one", want.arg_value[0], res_ch.value_one);
					check_field("value_two", want.arg_value[1], res_ch.value_two);
					check_field("value_three", want.arg_value[2], res_ch.value_three);
					check_field("value_four", want.arg_value[3], res_ch.value_four);
				end
			end
			// start a long hold when the driver asks for one
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 12);
				take = 1'b0;
			end else begin
				take = 1'b1;
			end
			res_ch.ready <= take;
		end
	end

	// End the run when nothing has been accepted for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns: no handshake for %0d cycles", $time, quiet);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : run
		int  seg_end;
		int  pick;
		bit  hold_done;
		bit  drain_done;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_WRITE;
		cmd_ch.address = '0;
		cmd_ch.write_byte = '0;
		cmd_ch.has_coding_byte = 1'b0;
		cmd_ch.arg_count = '0;
		cmd_ch.direct_wide = 1'b0;
		res_ch.ready = 1'b0;
		rx_calm = 1'b1;
		hold_req = 0;
		errors = 0;
		queued_items = 0;
		for (int a = 0; a < ARENA_DEPTH; a++) begin
			plan_bytes[a] = '0;
			plan_known[a] = 1'b0;
			arena_shadow[a] = '0;
		end

		// Directed: one shared byte image across the wrap point, decoded several ways
		gen_bursty = 1'b0;
		gen_calm = 1'b1;
		queue_write(12'd4094, 8'h5E);
		queue_write(12'd4095, 8'hFF);
		queue_write(12'd0, 8'h80);
		queue_write(12'd1, 8'h80);
		queue_write(12'd2, 8'h00);
		queue_write(12'd3, 8'hFF);
		queue_write(12'd4, 8'hFF);
		queue_write(12'd5, 8'hFF);
		queue_write(12'd6, 8'hFE);
		queue_write(12'd7, 8'h0C);
		queue_write(12'd8, 8'h7F);
		queue_write(12'd9, 8'hFF);
		// register, register, indirect, wide direct; then narrow direct
		queue_decode(12'd4093, 1'b1, 3'd4, 1'b1);
		queue_decode(12'd4093, 1'b1, 3'd4, 1'b0);
		// no arguments decoded; count above four saturates; partial count
		queue_decode(12'd4093, 1'b1, 3'd0, 1'b1);
		queue_decode(12'd4093, 1'b1, 3'd7, 1'b1);
		queue_decode(12'd4093, 1'b1, 3'd2, 1'b1);
		// lone direct argument, count ignored, narrow and wide, the wide one across the wrap
		queue_decode(12'd4093, 1'b0, 3'd5, 1'b0);
		queue_decode(12'd4094, 1'b0, 3'd0, 1'b1);
		queue_decode(12'd0, 1'b0, 3'd3, 1'b0);
		// kinds of zero between arguments; all-indirect with negative and positive values
		queue_decode(12'd6, 1'b1, 3'd4, 1'b0);
		queue_decode(12'd2, 1'b1, 3'd3, 1'b1);

		// Random: mostly whole instructions, some re-decodes and stray writes
		seg_end = queued_items;
		hold_done = 1'b0;
		drain_done = 1'b0;
		while (queued_items < ITEM_TARGET) begin
			if (queued_items >= seg_end) begin
				seg_end += 100;
				gen_bursty = ($urandom_range(0, 2) != 0);
				gen_calm = ($urandom_range(0, 3) == 0);
			end
			if (queued_items >= ITEM_TARGET - 150) begin
				gen_bursty = 1'b0;
				gen_calm = 1'b1;
			end
			// whole instructions, written and decoded with no gaps, against a stalled receiver
			if (!hold_done && queued_items >= 400) begin
				hold_done = 1'b1;
				queue_marker(SLOT_HOLD);
				gen_bursty = 1'b0;
				repeat (12) queue_fresh_instruction();
			end
			if (!drain_done && queued_items >= 800) begin
				drain_done = 1'b1;
				queue_marker(SLOT_DRAIN);
			end
			pick = $urandom_range(0, 19);
			if (pick < 14)
				queue_fresh_instruction();
			else if (pick < 17)
				queue_decode(ADDR_W'($urandom), 1'($urandom_range(0, 1)),
					CNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			else
				repeat ($urandom_range(1, 3)) queue_write(ADDR_W'($urandom), random_byte());
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every item to go in and every result to come out
		while (stim_q.size() > 0 || cmd_ch.valid || pending_decodes.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_decodes.size() != 0)
			$display("%0d decode results never arrived", pending_decodes.size());
		if (errors == 0 && pending_decodes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
